[sv/dctqz_pkg.sv]
// dctqz_pkg: shared types, tables and the cosine helper for the 8x8 dct quantizer
// used by the controller, the datapath and the top level; no dependencies
`timescale 1ns / 1ps

package dctqz_pkg;

    localparam int COS_W_MAX = 18;

    localparam logic [16:0] COS_Q16 [0:8] = '{
        17'd65536, 17'd64277, 17'd60547, 17'd54491, 17'd46341,
        17'd36410, 17'd25080, 17'd12785, 17'd0
    };

    localparam logic [7:0] BASE_LUMA [0:63] = '{
        8'd16, 8'd11, 8'd10, 8'd16, 8'd24, 8'd40, 8'd51, 8'd61,
        8'd12, 8'd12, 8'd14, 8'd19, 8'd26, 8'd58, 8'd60, 8'd55,
        8'd14, 8'd13, 8'd16, 8'd24, 8'd40, 8'd57, 8'd69, 8'd56,
        8'd14, 8'd17, 8'd22, 8'd29, 8'd51, 8'd87, 8'd80, 8'd62,
        8'd18, 8'd22, 8'd37, 8'd56, 8'd68, 8'd109, 8'd103, 8'd77,
        8'd24, 8'd35, 8'd55, 8'd64, 8'd81, 8'd104, 8'd113, 8'd92,
        8'd49, 8'd64, 8'd78, 8'd87, 8'd103, 8'd121, 8'd120, 8'd101,
        8'd72, 8'd92, 8'd95, 8'd98, 8'd112, 8'd100, 8'd103, 8'd99
    };

    localparam logic [7:0] BASE_CHROMA [0:63] = '{
        8'd17, 8'd18, 8'd24, 8'd47, 8'd99, 8'd99, 8'd99, 8'd99,
        8'd18, 8'd21, 8'd26, 8'd66, 8'd99, 8'd99, 8'd99, 8'd99,
        8'd24, 8'd26, 8'd56, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
        8'd47, 8'd66, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
        8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
        8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
        8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
        8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99
    };

    localparam logic [5:0] ZIGZAG [0:63] = '{
        6'd0, 6'd1, 6'd8, 6'd16, 6'd9, 6'd2, 6'd3, 6'd10,
        6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4, 6'd5,
        6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
        6'd27, 6'd20, 6'd13, 6'd6, 6'd7, 6'd14, 6'd21, 6'd28,
        6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
        6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
        6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
        6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
    };

    localparam logic       REG_QUALITY   = 1'b0;
    localparam logic [6:0] QUALITY_RESET = 7'd50;

    typedef struct packed {
        logic       smp_wr;
        logic [5:0] smp_addr;
        logic       chroma_ld;
        logic       mac_issue;
        logic       mac_first;
        logic       pass_col;
        logic [2:0] i;
        logic [2:0] j;
        logic [2:0] k;
        logic       row_wr;
        logic       scale;
        logic       round;
        logic       div_start;
        logic       div_coef;
        logic       coef_wr;
        logic       out_rd;
        logic       out_ld;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_busy;
    } t_sts;

    // signed cosine of (2p+1)*f*pi/16 at frac_bits fraction bits
    function automatic logic signed [COS_W_MAX-1:0] cos_coef(
        input logic [2:0] f,
        input logic [2:0] p,
        input int         frac_bits
    );
        logic [6:0] prod;
        logic [4:0] m;
        logic [3:0] k;
        logic       neg;
        int         mag;
        prod = 7'({p, 1'b1}) * 7'(f);
        m    = prod[4:0];
        if (m <= 5'd8) begin
            k   = m[3:0];
            neg = 1'b0;
        end else if (m <= 5'd16) begin
            k   = 4'(5'd16 - m);
            neg = 1'b1;
        end else if (m <= 5'd24) begin
            k   = 4'(m - 5'd16);
            neg = 1'b1;
        end else begin
            k   = 4'(6'd32 - {1'b0, m});
            neg = 1'b0;
        end
        mag = (int'(COS_Q16[k]) + ((1 << (16 - frac_bits)) >> 1)) >>> (16 - frac_bits);
        return neg ? COS_W_MAX'(-mag) : COS_W_MAX'(mag);
    endfunction

endpackage

[sv/dctqz_in_if.sv]
// dctqz_in_if: sample request channel of the dct quantizer
// valid/ready handshake with the sample and table select; no dependencies
`timescale 1ns / 1ps

interface dctqz_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample;
    logic       use_chroma_table;

    modport source (output valid, output sample, output use_chroma_table, input ready);
    modport sink   (input valid, input sample, input use_chroma_table, output ready);
endinterface

[sv/dctqz_out_if.sv]
// dctqz_out_if: coefficient request channel of the dct quantizer
// valid/ready handshake with the coefficient and block end flag; no dependencies
`timescale 1ns / 1ps

interface dctqz_out_if;
    logic              valid;
    logic              ready;
    logic signed [11:0] coefficient;
    logic              last_of_block;

    modport source (output valid, output coefficient, output last_of_block, input ready);
    modport sink   (input valid, input coefficient, input last_of_block, output ready);
endinterface

[sv/block_dct_quantize_zigzag.sv]
// block_dct_quantize_zigzag: 8x8 forward dct, quantizer and zigzag scan
// depends on dctqz_pkg, dctqz_in_if, dctqz_out_if, dctqz_ctrl, dctqz_dp
//
// usage
// - i_in takes 64 samples of one 8x8 block in raster order; use_chroma_table
//   is taken with the 64th sample of the block
// - o_out gives the 64 quantized coefficients in zigzag order, last_of_block
//   set on the 64th
// - apb port holds the quality register at byte address 0, reset value 50
// - samples are taken one per cycle while collecting; after the 64th the
//   block computes on one shared multiply-accumulate unit and one shared
//   radix-2 divider: each row-pass value takes the mac, a pipeline drain
//   and a write; each column value takes the mac, a drain, scale, round,
//   two divisions and a write; each output is then read and loaded
// - samples of the next block are taken while the coefficients drain, up to
//   the 63rd; the 64th waits until the last coefficient is taken
// - a stalled receiver holds the output register and pauses the readout
// - reset clears the sample count, state machine and output valid
`timescale 1ns / 1ps

module block_dct_quantize_zigzag #(
    parameter int COS_FRAC_BITS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dctqz_in_if.sink    i_in,
    dctqz_out_if.source o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dctqz_pkg::*;

    t_cmd       cmd;
    t_sts       sts;
    logic [6:0] r_quality;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quality <= QUALITY_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_QUALITY)) begin
            r_quality <= pwdata[6:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_QUALITY) ? {25'd0, r_quality} : 32'd0;

    dctqz_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dctqz_dp #(
        .COS_FRAC_BITS (COS_FRAC_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_quality          (r_quality),
        .i_sample           (i_in.sample),
        .i_use_chroma_table (i_in.use_chroma_table),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_coefficient      (o_out.coefficient),
        .o_last_of_block    (o_out.last_of_block)
    );
endmodule

[sv/dctqz_div.sv]
// dctqz_div: radix-2 restoring divider, 16-bit dividend by 8-bit divisor
// one quotient bit per cycle; no dependencies
`timescale 1ns / 1ps

module dctqz_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [7:0]  i_divisor,
    output logic        o_busy,
    output logic [15:0] o_quotient
);
    logic        r_busy;
    logic [3:0]  r_cnt;
    logic [7:0]  r_rem;
    logic [15:0] r_quo;
    logic [7:0]  r_den;
    logic [8:0]  shifted;
    logic        fits;

    assign shifted = {r_rem, r_quo[15]};
    assign fits    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == 4'd15) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? 8'(shifted - {1'b0, r_den}) : shifted[7:0];
            r_quo <= {r_quo[14:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;
endmodule

[sv/dctqz_dp.sv]
// dctqz_dp: datapath with sample, row and coefficient stores, shared mac,
// rounding, quantizer entry and divider; depends on dctqz_pkg and dctqz_div
`timescale 1ns / 1ps

module dctqz_dp #(
    parameter int COS_FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dctqz_pkg::t_cmd    i_cmd,
    output dctqz_pkg::t_sts    o_sts,
    input  logic [6:0]         i_quality,
    input  logic [7:0]         i_sample,
    input  logic               i_use_chroma_table,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [11:0] o_coefficient,
    output logic               o_last_of_block
);
    import dctqz_pkg::*;

    localparam int CW = COS_FRAC_BITS + 2;
    localparam int PW = 20 + CW;
    localparam int AW = PW + 3;
    localparam int SW = AW + CW;
    localparam int T0 = 8 + COS_FRAC_BITS + 2;
    localparam int T1 = 8 + 2 * COS_FRAC_BITS + 2;
    localparam int T2 = 8 + COS_FRAC_BITS + 3;
    localparam logic signed [CW-1:0] C40 = CW'(cos_coef(3'd4, 3'd0, COS_FRAC_BITS));
    localparam logic signed [AW-1:0] ROW_HALF = AW'(64'sd1 <<< (COS_FRAC_BITS - 9));
    localparam logic signed [SW-1:0] HALF0 = SW'(64'sd1 <<< (T0 - 1));
    localparam logic signed [SW-1:0] HALF1 = SW'(64'sd1 <<< (T1 - 1));
    localparam logic signed [SW-1:0] HALF2 = SW'(64'sd1 <<< (T2 - 1));
    localparam logic signed [SW-1:0] SAT_HI = SW'(64'sd2047);
    localparam logic signed [SW-1:0] SAT_LO = SW'(-64'sd2048);

    logic [7:0]         r_smp_mem  [0:63];
    logic [19:0]        r_row_mem  [0:63];
    logic [11:0]        r_coef_mem [0:63];

    logic [7:0]         r_smp_q;
    logic signed [19:0] r_row_q;
    logic [11:0]        r_coef_q;
    logic               r_chroma;

    logic signed [CW-1:0] r_cos1;
    logic               r_v1;
    logic               r_first1;
    logic               r_col1;
    logic signed [PW-1:0] r_prod;
    logic               r_v2;
    logic               r_first2;
    logic signed [AW-1:0] r_acc;
    logic signed [SW-1:0] r_sc;
    logic signed [11:0] r_r;

    logic               r_out_valid;
    logic [11:0]        r_out_coef;
    logic               r_out_last;

    logic [2:0]         freq;
    logic signed [CW-1:0] cos_cur;
    logic signed [8:0]  smp_c;
    logic signed [19:0] opa;
    logic signed [AW-1:0] row_sum;
    logic [19:0]        row_val;
    logic [1:0]         zeros;
    logic signed [SW-1:0] rnd_x;
    logic [SW-1:0]      rnd_mag;
    logic [SW-1:0]      rnd_shm;
    logic signed [SW-1:0] rnd_q;
    logic signed [11:0] sat_r;
    logic [6:0]         qc;
    logic [7:0]         base;
    logic [15:0]        qe_num;
    logic [7:0]         qe_den;
    logic [7:0]         qe_val;
    logic [11:0]        r_mag;
    logic [15:0]        div_num;
    logic [7:0]         div_den;
    logic               div_busy;
    logic [15:0]        quot;
    logic [11:0]        coef_val;

    // stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.smp_wr) begin
            r_smp_mem[i_cmd.smp_addr] <= i_sample;
        end
        if (i_cmd.mac_issue) begin
            r_smp_q <= r_smp_mem[{i_cmd.i, i_cmd.k}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_wr) begin
            r_row_mem[{i_cmd.i, i_cmd.j}] <= row_val;
        end
        if (i_cmd.mac_issue) begin
            r_row_q <= r_row_mem[{i_cmd.k, i_cmd.j}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_wr) begin
            r_coef_mem[{i_cmd.i, i_cmd.j}] <= coef_val;
        end
        if (i_cmd.out_rd) begin
            r_coef_q <= r_coef_mem[ZIGZAG[{i_cmd.i, i_cmd.j}]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.chroma_ld) begin
            r_chroma <= i_use_chroma_table;
        end
    end

    // mac pipeline
    assign freq    = i_cmd.pass_col ? i_cmd.i : i_cmd.j;
    assign cos_cur = CW'(cos_coef(freq, i_cmd.k, COS_FRAC_BITS));
    assign smp_c   = $signed({1'b0, r_smp_q}) - 9'sd128;
    assign opa     = r_col1 ? r_row_q : {{11{smp_c[8]}}, smp_c};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac_issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cos1   <= cos_cur;
        r_first1 <= i_cmd.mac_first;
        r_col1   <= i_cmd.pass_col;
        r_first2 <= r_first1;
        r_prod   <= opa * r_cos1;
        if (r_v2) begin
            r_acc <= r_first2 ? AW'(r_prod) : r_acc + AW'(r_prod);
        end
    end

    // row rounding
    assign row_sum = r_acc + ROW_HALF;
    assign row_val = 20'(row_sum >>> (COS_FRAC_BITS - 8));

    // column scale and rounding
    assign zeros = 2'(i_cmd.i == 3'd0) + 2'(i_cmd.j == 3'd0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_sc <= (zeros == 2'd1) ? r_acc * C40 : SW'(r_acc);
        end
        if (i_cmd.round) begin
            r_r <= sat_r;
        end
    end

    always_comb begin
        case (zeros)
            2'd0:    rnd_x = r_sc + HALF0;
            2'd1:    rnd_x = r_sc + HALF1;
            2'd2:    rnd_x = r_sc + HALF2;
            default: rnd_x = r_sc + HALF0;
        endcase
        rnd_mag = rnd_x[SW-1] ? SW'(-rnd_x) : rnd_x;
        case (zeros)
            2'd0:    rnd_shm = rnd_mag >> T0;
            2'd1:    rnd_shm = rnd_mag >> T1;
            2'd2:    rnd_shm = rnd_mag >> T2;
            default: rnd_shm = rnd_mag >> T0;
        endcase
        rnd_q = rnd_x[SW-1] ? -$signed(rnd_shm) : $signed(rnd_shm);
        if (rnd_q > SAT_HI) begin
            sat_r = 12'sd2047;
        end else if (rnd_q < SAT_LO) begin
            sat_r = -12'sd2048;
        end else begin
            sat_r = 12'(rnd_q);
        end
    end

    // quantizer entry
    assign base = r_chroma ? BASE_CHROMA[{i_cmd.i, i_cmd.j}] : BASE_LUMA[{i_cmd.i, i_cmd.j}];

    always_comb begin
        if (i_quality == 7'd0) begin
            qc = 7'd1;
        end else if (i_quality > 7'd100) begin
            qc = 7'd100;
        end else begin
            qc = i_quality;
        end
        if (qc <= 7'd25) begin
            qe_num = {7'd0, base, 1'b0};
            qe_den = 8'd1;
        end else if (qc < 7'd50) begin
            qe_num = 16'(base) * 16'd50;
            qe_den = {1'b0, qc};
        end else if (qc <= 7'd75) begin
            qe_num = 16'(base) * 16'(7'd100 - qc);
            qe_den = 8'd50;
        end else begin
            qe_num = {9'd0, base[7:1]};
            qe_den = 8'd1;
        end
    end

    assign qe_val = (quot == 16'd0) ? 8'd1 : ((quot > 16'd255) ? 8'd255 : quot[7:0]);
    assign r_mag  = r_r[11] ? 12'(-r_r) : r_r;
    assign div_num = i_cmd.div_coef ? {4'd0, r_mag} : qe_num;
    assign div_den = i_cmd.div_coef ? qe_val : qe_den;

    dctqz_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_busy     (div_busy),
        .o_quotient (quot)
    );

    assign coef_val = r_r[11] ? 12'(-quot) : quot[11:0];

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_coef <= r_coef_q;
            r_out_last <= ({i_cmd.i, i_cmd.j} == 6'd63);
        end
    end

    assign o_sts.div_busy = div_busy;
    assign o_sts.out_busy = r_out_valid;
    assign o_out_valid     = r_out_valid;
    assign o_coefficient   = r_out_coef;
    assign o_last_of_block = r_out_last;
endmodule

[sv/dctqz_ctrl.sv]
// dctqz_ctrl: sequencer for sample intake, row pass, column pass with
// quantizing, and zigzag readout; depends on dctqz_pkg
`timescale 1ns / 1ps

module dctqz_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  dctqz_pkg::t_sts i_sts,
    output dctqz_pkg::t_cmd o_cmd
);
    import dctqz_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ROW_MAC  = 4'd1;
    localparam logic [3:0] S_ROW_WAIT = 4'd2;
    localparam logic [3:0] S_ROW_WR   = 4'd3;
    localparam logic [3:0] S_COL_MAC  = 4'd4;
    localparam logic [3:0] S_COL_WAIT = 4'd5;
    localparam logic [3:0] S_COL_SCL  = 4'd6;
    localparam logic [3:0] S_COL_RND  = 4'd7;
    localparam logic [3:0] S_QE_WAIT  = 4'd8;
    localparam logic [3:0] S_CF_START = 4'd9;
    localparam logic [3:0] S_CF_WAIT  = 4'd10;
    localparam logic [3:0] S_COL_WR   = 4'd11;
    localparam logic [3:0] S_OUT_RD   = 4'd12;
    localparam logic [3:0] S_OUT_LD   = 4'd13;
    localparam logic [3:0] S_OUT_WT   = 4'd14;

    logic [3:0] r_state, n_state;
    logic [2:0] r_i, n_i;
    logic [2:0] r_j, n_j;
    logic [2:0] r_k, n_k;
    logic [5:0] r_count, n_count;
    logic       in_acc;
    logic       out_phase;

    assign out_phase  = (r_state == S_OUT_RD) || (r_state == S_OUT_LD) ||
                        (r_state == S_OUT_WT);
    assign o_in_ready = (r_state == S_IDLE) || (out_phase && (r_count != 6'd63));
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_count = in_acc ? r_count + 6'd1 : r_count;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (r_count == 6'd63)) begin
                    n_state = S_ROW_MAC;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                end
            end
            S_ROW_MAC, S_COL_MAC: begin
                n_k = r_k + 3'd1;
                if (r_k == 3'd7) begin
                    n_state = (r_state == S_ROW_MAC) ? S_ROW_WAIT : S_COL_WAIT;
                end
            end
            S_ROW_WAIT, S_COL_WAIT: begin
                n_k = r_k + 3'd1;
                if (r_k == 3'd1) begin
                    n_k     = '0;
                    n_state = (r_state == S_ROW_WAIT) ? S_ROW_WR : S_COL_SCL;
                end
            end
            S_ROW_WR: begin
                n_j     = r_j + 3'd1;
                n_state = S_ROW_MAC;
                if (r_j == 3'd7) begin
                    n_i = r_i + 3'd1;
                    if (r_i == 3'd7) begin
                        n_state = S_COL_MAC;
                    end
                end
            end
            S_COL_SCL:  n_state = S_COL_RND;
            S_COL_RND:  n_state = S_QE_WAIT;
            S_QE_WAIT: begin
                if (!i_sts.div_busy) begin
                    n_state = S_CF_START;
                end
            end
            S_CF_START: n_state = S_CF_WAIT;
            S_CF_WAIT: begin
                if (!i_sts.div_busy) begin
                    n_state = S_COL_WR;
                end
            end
            S_COL_WR: begin
                n_j     = r_j + 3'd1;
                n_state = S_COL_MAC;
                if (r_j == 3'd7) begin
                    n_i = r_i + 3'd1;
                    if (r_i == 3'd7) begin
                        n_state = S_OUT_RD;
                    end
                end
            end
            S_OUT_RD:   n_state = S_OUT_LD;
            S_OUT_LD:   n_state = S_OUT_WT;
            S_OUT_WT: begin
                if (!i_sts.out_busy) begin
                    {n_i, n_j} = {r_i, r_j} + 6'd1;
                    n_state    = ({r_i, r_j} == 6'd63) ? S_IDLE : S_OUT_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.smp_wr    = in_acc;
        o_cmd.smp_addr  = r_count;
        o_cmd.chroma_ld = in_acc && (r_count == 6'd63);
        o_cmd.i         = r_i;
        o_cmd.j         = r_j;
        o_cmd.k         = r_k;
        o_cmd.mac_issue = (r_state == S_ROW_MAC) || (r_state == S_COL_MAC);
        o_cmd.mac_first = r_k == 3'd0;
        o_cmd.pass_col  = r_state == S_COL_MAC;
        o_cmd.row_wr    = r_state == S_ROW_WR;
        o_cmd.scale     = r_state == S_COL_SCL;
        o_cmd.round     = r_state == S_COL_RND;
        o_cmd.div_start = (r_state == S_COL_RND) || (r_state == S_CF_START);
        o_cmd.div_coef  = r_state == S_CF_START;
        o_cmd.coef_wr   = r_state == S_COL_WR;
        o_cmd.out_rd    = r_state == S_OUT_RD;
        o_cmd.out_ld    = r_state == S_OUT_LD;
    end
endmodule
